FILE: design/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/lpd_pkg.sv
// Types, constants and helpers of the length-prefixed packet deframer.
`default_nettype none
package lpd_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 32;
  localparam int STATUS_W    = 3;
  localparam int LCODE_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 3'd4;

  localparam logic [BYTE_W-1:0] CODE_ONE_RESET   = 8'd1;
  localparam logic [BYTE_W-1:0] CODE_TWO_RESET   = 8'd2;
  localparam logic [BYTE_W-1:0] CODE_THREE_RESET = 8'd3;
  localparam logic [BYTE_W-1:0] CODE_FOUR_RESET  = 8'd4;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 32'd4096;

  // status codes seen on the output
  localparam logic [STATUS_W-1:0] ST_HEAD     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LEN      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BODY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 3'd5;

  // length-field size decoded from a type byte; zero means no match
  localparam logic [LCODE_W-1:0] LC_NONE  = 3'd0;
  localparam logic [LCODE_W-1:0] LC_ONE   = 3'd1;
  localparam logic [LCODE_W-1:0] LC_TWO   = 3'd2;
  localparam logic [LCODE_W-1:0] LC_THREE = 3'd3;
  localparam logic [LCODE_W-1:0] LC_FOUR  = 3'd4;

  typedef enum logic [5:0] {
    PH_HEAD     = 6'b000001,
    PH_LEN      = 6'b000010,
    PH_BODY     = 6'b000100,
    PH_READY    = 6'b001000,
    PH_UNKNOWN  = 6'b010000,
    PH_OVERSIZE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code_one;
    logic [BYTE_W-1:0] code_two;
    logic [BYTE_W-1:0] code_three;
    logic [BYTE_W-1:0] code_four;
    logic [LEN_W-1:0]  max_payload;
  } cfg_regs_t;

  // one classified item waiting for the back end
  typedef struct packed {
    logic               clear;
    logic [BYTE_W-1:0]  rx_byte;
    logic [LCODE_W-1:0] len_code;
  } queue_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  function automatic logic [STATUS_W-1:0] phase_status(input phase_t ph);
    logic [STATUS_W-1:0] st;
    case (ph)
      PH_LEN:      st = ST_LEN;
      PH_BODY:     st = ST_BODY;
      PH_READY:    st = ST_READY;
      PH_UNKNOWN:  st = ST_UNKNOWN;
      PH_OVERSIZE: st = ST_OVERSIZE;
      default:     st = ST_HEAD;
    endcase
    return st;
  endfunction

endpackage
`default_nettype wire

FILE: design/lpd_front.sv
// Front end: accepts input items and decodes type bytes against the codes.
`default_nettype none
module lpd_front (
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [lpd_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
  input  wire logic                            s_tuser,   // [0] opcode
  input  wire lpd_pkg::cfg_regs_t              cfg,
  input  wire lpd_pkg::queue_status_t          q_status,
  output logic                                 push,
  output lpd_pkg::queue_item_t                 push_item
);

  logic [lpd_pkg::BYTE_W-1:0]  rx_byte;
  logic [lpd_pkg::LCODE_W-1:0] len_code;

  assign rx_byte = s_tdata[lpd_pkg::BYTE_W-1:0];

  // first matching code in register order wins
  always_comb begin
    if (rx_byte == cfg.code_one) begin
      len_code = lpd_pkg::LC_ONE;
    end else if (rx_byte == cfg.code_two) begin
      len_code = lpd_pkg::LC_TWO;
    end else if (rx_byte == cfg.code_three) begin
      len_code = lpd_pkg::LC_THREE;
    end else if (rx_byte == cfg.code_four) begin
      len_code = lpd_pkg::LC_FOUR;
    end else begin
      len_code = lpd_pkg::LC_NONE;
    end
  end

  assign s_tready           = !q_status.full;
  assign push               = s_tvalid && s_tready;
  assign push_item.clear    = s_tuser;
  assign push_item.rx_byte  = rx_byte;
  assign push_item.len_code = len_code;

endmodule
`default_nettype wire

FILE: design/lpd_queue.sv
// Short FIFO of classified items between front and back ends.
`default_nettype none
module lpd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire lpd_pkg::queue_item_t  push_item,
  input  wire logic                  pop,
  output lpd_pkg::queue_item_t       head,
  output lpd_pkg::queue_status_t     status
);

  lpd_pkg::queue_item_t              slots [lpd_pkg::QUEUE_DEPTH];
  logic [lpd_pkg::QPTR_W-1:0]        wr_ptr;
  logic [lpd_pkg::QPTR_W-1:0]        rd_ptr;
  logic [lpd_pkg::QCNT_W-1:0]        count;

  function automatic logic [lpd_pkg::QPTR_W-1:0] ptr_inc(input logic [lpd_pkg::QPTR_W-1:0] p);
    logic [lpd_pkg::QPTR_W-1:0] r;
    if (p == lpd_pkg::QPTR_W'(lpd_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule
`default_nettype wire

FILE: design/lpd_back.sv
// Back end: deframing state machine and registered result stage.
`default_nettype none
module lpd_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lpd_pkg::queue_status_t          q_status,
  input  wire lpd_pkg::queue_item_t            q_head,
  input  wire logic [lpd_pkg::LEN_W-1:0]       max_payload,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [lpd_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  lpd_pkg::phase_t                 phase, phase_next;
  logic [lpd_pkg::LCODE_W-1:0]     len_total, len_total_next;
  logic [lpd_pkg::LCODE_W-1:0]     len_seen, len_seen_next;
  logic [lpd_pkg::LEN_W-1:0]       length_accum, length_accum_next;
  logic [lpd_pkg::LEN_W-1:0]       body_count, body_count_next;
  logic [lpd_pkg::LEN_W-1:0]       body_inc;
  logic [lpd_pkg::LEN_W-1:0]       len_shifted;
  logic [lpd_pkg::LEN_W-1:0]       accum_new;

  logic                            res_valid;
  logic [lpd_pkg::BYTE_W-1:0]      res_byte;
  logic [lpd_pkg::LEN_W-1:0]       res_index;
  logic                            res_last;

  logic [lpd_pkg::STATUS_W-1:0]    out_status;
  logic                            out_valid;
  logic [lpd_pkg::BYTE_W-1:0]      out_byte;
  logic [lpd_pkg::LEN_W-1:0]       out_index;
  logic                            out_last;

  assign pop = !q_status.empty && (!m_tvalid || m_tready);

  assign len_shifted = lpd_pkg::LEN_W'(q_head.rx_byte) << {len_seen[1:0], 3'b000};
  assign accum_new   = length_accum | len_shifted;
  assign body_inc    = body_count + 1'b1;

  always_comb begin
    phase_next        = phase;
    len_total_next    = len_total;
    len_seen_next     = len_seen;
    length_accum_next = length_accum;
    body_count_next   = body_count;
    res_valid         = 1'b0;
    res_byte          = '0;
    res_index         = '0;
    res_last          = 1'b0;
    if (q_head.clear) begin
      phase_next        = lpd_pkg::PH_HEAD;
      len_total_next    = '0;
      len_seen_next     = '0;
      length_accum_next = '0;
      body_count_next   = '0;
    end else begin
      case (phase)
        lpd_pkg::PH_LEN: begin
          length_accum_next = accum_new;
          len_seen_next     = len_seen + 1'b1;
          if ((len_seen + 1'b1) >= len_total) begin
            if (accum_new == '0 || accum_new > max_payload) begin
              phase_next = lpd_pkg::PH_OVERSIZE;
            end else begin
              phase_next      = lpd_pkg::PH_BODY;
              body_count_next = '0;
            end
          end
        end
        lpd_pkg::PH_BODY: begin
          res_valid       = 1'b1;
          res_byte        = q_head.rx_byte;
          res_index       = body_count;
          body_count_next = body_inc;
          if (body_inc >= length_accum) begin
            res_last   = 1'b1;
            phase_next = lpd_pkg::PH_READY;
          end
        end
        lpd_pkg::PH_READY, lpd_pkg::PH_UNKNOWN, lpd_pkg::PH_OVERSIZE: begin
        end
        default: begin
          if (q_head.len_code == lpd_pkg::LC_NONE) begin
            phase_next = lpd_pkg::PH_UNKNOWN;
          end else begin
            phase_next        = lpd_pkg::PH_LEN;
            len_total_next    = q_head.len_code;
            len_seen_next     = '0;
            length_accum_next = '0;
            body_count_next   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lpd_pkg::PH_HEAD;
      len_total    <= '0;
      len_seen     <= '0;
      length_accum <= '0;
      body_count   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        len_total    <= len_total_next;
        len_seen     <= len_seen_next;
        length_accum <= length_accum_next;
        body_count   <= body_count_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid     <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_status <= lpd_pkg::phase_status(phase_next);
      out_valid  <= res_valid;
      out_byte   <= res_byte;
      out_index  <= res_index;
      out_last   <= res_last;
    end
  end

  assign m_tdata = {5'b0, out_index, out_byte, out_status};
  assign m_tuser = out_valid;
  assign m_tlast = out_last;

endmodule
`default_nettype wire

FILE: design/length_prefixed_packet_deframer_unit.sv
// Top level of the length-prefixed packet deframer: config registers and wiring.
`default_nettype none
`include "assert_macros.svh"
// Type/length/value deframer. Each input item is either a received byte or a
// clear (s_tuser high). A byte seen while waiting for a header is compared
// with the four type codes; the first match selects a length field of one to
// four bytes, sent least significant byte first. A zero length or one above
// max_payload ends in the sticky oversize status, an unknown type byte in the
// sticky unknown-type status. Body bytes come out with data valid (m_tuser),
// their index and tlast on the final one; afterwards bytes are ignored until
// a clear. Every input item gives exactly one result item carrying the phase
// after that item. Throughput is one item per clock while m_tready stays high:
// the front end decodes the type byte, a two-entry queue decouples it from
// the back end, and the back end updates its length/count state and
// registers the result (the body count increment and compare is the longest
// path). An accepted item is first written into the queue and then popped
// into the result register, which raises m_tvalid.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the block is idle; indexes beyond 4 are ignored.
module length_prefixed_packet_deframer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [lpd_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] rx_byte
  input  wire logic                             s_tuser,  // [0] opcode (1 = clear)
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [lpd_pkg::M_TDATA_W-1:0]         m_tdata,  // [2:0] status, [10:3] data_byte,
                                                          // [42:11] byte_index, zero above
  output logic                                  m_tuser,  // [0] data_valid
  output logic                                  m_tlast,  // last
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lpd_pkg::LEN_W-1:0]        cfg_data
);

  lpd_pkg::cfg_regs_t     cfg;
  lpd_pkg::queue_status_t q_status;
  lpd_pkg::queue_item_t   push_item;
  lpd_pkg::queue_item_t   q_head;
  logic                   push;
  logic                   pop;
  logic                   cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // register file; codes take the low byte of the write data
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_one    <= lpd_pkg::CODE_ONE_RESET;
      cfg.code_two    <= lpd_pkg::CODE_TWO_RESET;
      cfg.code_three  <= lpd_pkg::CODE_THREE_RESET;
      cfg.code_four   <= lpd_pkg::CODE_FOUR_RESET;
      cfg.max_payload <= lpd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lpd_pkg::CFG_CODE_ONE:    cfg.code_one    <= cfg_data[lpd_pkg::BYTE_W-1:0];
        lpd_pkg::CFG_CODE_TWO:    cfg.code_two    <= cfg_data[lpd_pkg::BYTE_W-1:0];
        lpd_pkg::CFG_CODE_THREE:  cfg.code_three  <= cfg_data[lpd_pkg::BYTE_W-1:0];
        lpd_pkg::CFG_CODE_FOUR:   cfg.code_four   <= cfg_data[lpd_pkg::BYTE_W-1:0];
        lpd_pkg::CFG_MAX_PAYLOAD: cfg.max_payload <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lpd_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg       (cfg),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  lpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  lpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .q_head      (q_head),
    .max_payload (cfg.max_payload),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  // back pressure on the input only when the queue is full
  `ASSERT_ALWAYS(a_ready_only_full, clk, rst, s_tready || q_status.full, "input stalled with room in queue")
  // a last flag only rides on a payload byte
  `ASSERT_ALWAYS(a_last_has_data, clk, rst, !(m_tvalid && m_tlast) || m_tuser, "tlast without payload byte")
  // a payload byte is only reported in body or ready phase
  `ASSERT_ALWAYS(a_data_status, clk, rst, !(m_tvalid && m_tuser) || m_tdata[2:0] == lpd_pkg::ST_BODY || m_tdata[2:0] == lpd_pkg::ST_READY, "payload byte with wrong status")
  // a popped clear always yields the header-wait status
  `ASSERT_NEXT(a_clear_head, clk, rst, pop && q_head.clear, m_tvalid && m_tdata[2:0] == lpd_pkg::ST_HEAD && !m_tuser, "clear did not restart at header")

endmodule
`default_nettype wire

FILE: dv/tb_length_prefixed_packet_deframer_unit.sv
// Self-checking testbench for the length-prefixed packet deframer unit.
module tb_length_prefixed_packet_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lpd_pkg::*;

  // item kinds carried on s_tuser
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam int unsigned RANDOM_ITEMS = 1750;  // random items that reach the framing logic
  localparam int unsigned QUIET_TAIL   = 200;   // closing stretch run without any idling
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 8;     // extra wait after the drain, for stray results
  localparam int unsigned TIMEOUT_NS   = 2_000_000;

  // one result item, unpacked from m_tdata / m_tuser / m_tlast
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                data_valid;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    byte_index;
    logic                tail;
  } deframe_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data  = '0;

  // idling controls: quiet switches all idling off for the closing stretch
  logic quiet       = 1'b0;
  logic sender_gaps = 1'b1;
  logic sink_stalls = 1'b1;

  // predictor copy of the registers and framing state
  logic [BYTE_W-1:0]   type_code [4];
  logic [LEN_W-1:0]    payload_limit;
  logic [STATUS_W-1:0] rx_phase;
  logic [2:0]          len_field_bytes;
  logic [2:0]          len_bytes_got;
  logic [LEN_W-1:0]    pkt_length;
  logic [LEN_W-1:0]    body_seen;

  // register values as last programmed, for shaping the stimulus
  logic [BYTE_W-1:0] plan_code [4];
  logic [LEN_W-1:0]  plan_limit;

  deframe_result_t pending_results [$];

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned useful_items  = 0;
  int unsigned packets_done  = 0;
  int unsigned unknown_ends  = 0;
  int unsigned oversize_ends = 0;
  int unsigned reg_phases    = 0;
  int unsigned failures      = 0;

  length_prefixed_packet_deframer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // back to waiting for a type byte, counters and length cleared
  function automatic void restart_framing();
    rx_phase        = ST_HEAD;
    len_field_bytes = '0;
    len_bytes_got   = '0;
    pkt_length      = '0;
    body_seen       = '0;
  endfunction

  // advances the framing state by one item and returns the result it gives
  function automatic deframe_result_t predict_deframe(input logic op,
                                                      input logic [BYTE_W-1:0] rx);
    deframe_result_t res;
    logic [2:0]      field_size;
    res = '0;
    if (op == OP_CLEAR) begin
      restart_framing();
    end else begin
      case (rx_phase)
        ST_LEN: begin
          // length arrives least significant byte first
          pkt_length    = pkt_length | ({{(LEN_W-BYTE_W){1'b0}}, rx} << (8 * len_bytes_got[1:0]));
          len_bytes_got = len_bytes_got + 3'd1;
          if (len_bytes_got >= len_field_bytes) begin
            if (pkt_length == '0 || pkt_length > payload_limit) begin
              rx_phase = ST_OVERSIZE;
            end else begin
              rx_phase  = ST_BODY;
              body_seen = '0;
            end
          end
        end
        ST_BODY: begin
          res.data_valid = 1'b1;
          res.data_byte  = rx;
          res.byte_index = body_seen;
          body_seen      = body_seen + 1'b1;
          if (body_seen >= pkt_length) begin
            res.tail = 1'b1;
            rx_phase = ST_READY;
          end
        end
        ST_READY, ST_UNKNOWN, ST_OVERSIZE: ;  // sticky: byte dropped
        default: begin
          // first matching code in register order decides the field size
          if (rx == type_code[0])      field_size = 3'd1;
          else if (rx == type_code[1]) field_size = 3'd2;
          else if (rx == type_code[2]) field_size = 3'd3;
          else if (rx == type_code[3]) field_size = 3'd4;
          else                         field_size = 3'd0;
          if (field_size == 3'd0) begin
            rx_phase = ST_UNKNOWN;
          end else begin
            rx_phase        = ST_LEN;
            len_field_bytes = field_size;
            len_bytes_got   = '0;
            pkt_length      = '0;
            body_seen       = '0;
          end
        end
      endcase
    end
    res.status = rx_phase;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: register writes and accepted items feed the predictor, each
  // accepted result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    deframe_result_t     want;
    deframe_result_t     got;
    logic [STATUS_W-1:0] was;
    if (rst) begin
      type_code[0]  = CODE_ONE_RESET;
      type_code[1]  = CODE_TWO_RESET;
      type_code[2]  = CODE_THREE_RESET;
      type_code[3]  = CODE_FOUR_RESET;
      payload_limit = MAX_PAYLOAD_RESET;
      restart_framing();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CODE_ONE:    type_code[0]  = cfg_data[BYTE_W-1:0];
          CFG_CODE_TWO:    type_code[1]  = cfg_data[BYTE_W-1:0];
          CFG_CODE_THREE:  type_code[2]  = cfg_data[BYTE_W-1:0];
          CFG_CODE_FOUR:   type_code[3]  = cfg_data[BYTE_W-1:0];
          CFG_MAX_PAYLOAD: payload_limit = cfg_data;
          default: ;  // indexes past the register list do nothing
        endcase
      end
      if (s_tvalid && s_tready) begin
        was = rx_phase;
        if (s_tuser == OP_CLEAR || was == ST_HEAD || was == ST_LEN || was == ST_BODY)
          useful_items++;
        want = predict_deframe(s_tuser, s_tdata[BYTE_W-1:0]);
        if (want.tail) packets_done++;
        if (want.status != was && want.status == ST_UNKNOWN)  unknown_ends++;
        if (want.status != was && want.status == ST_OVERSIZE) oversize_ends++;
        pending_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.status     = m_tdata[STATUS_W-1:0];
        got.data_byte  = m_tdata[STATUS_W +: BYTE_W];
        got.byte_index = m_tdata[STATUS_W+BYTE_W +: LEN_W];
        got.data_valid = m_tuser;
        got.tail       = m_tlast;
        results_seen++;
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("[%0t] result with nothing outstanding: status %0d valid %b byte %h",
                     $realtime, got.status, got.data_valid, got.data_byte);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.data_valid !== want.data_valid ||
              got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
              got.tail !== want.tail) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display({"[%0t] result %0d (exp/got): status %0d/%0d valid %b/%b ",
                        "byte %h/%h index %0d/%0d last %b/%b"},
                       $realtime, results_seen, want.status, got.status,
                       want.data_valid, got.data_valid, want.data_byte, got.data_byte,
                       want.byte_index, got.byte_index, want.tail, got.tail);
          end
        end
      end
    end
  end

  // result side: ready drops at random for a burst of random length
  initial begin : sink_ready
    forever begin
      @(posedge clk);
      if (!quiet && sink_stalls && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // s_tvalid stays up after the handshake so back-to-back items flow; whoever
  // stops sending lowers it
  task automatic send_item(input logic op, input logic [BYTE_W-1:0] rx);
    if (!quiet && sender_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= rx;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] frame [$]);
    foreach (frame[k]) send_item(OP_BYTE, frame[k]);
  endtask

  // stop sending and hold until every item has its result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                           input logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // only called with nothing in flight
  task automatic program_regs(input logic [BYTE_W-1:0] c1, c2, c3, c4,
                              input logic [LEN_W-1:0] limit);
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_IDX_W'($urandom_range(CFG_MAX_PAYLOAD + 1, (1 << CFG_IDX_W) - 1)),
                $urandom);
    // codes go out with junk above bit 7, which must be dropped
    write_reg(CFG_CODE_ONE,   {(LEN_W-BYTE_W)'($urandom), c1});
    write_reg(CFG_CODE_TWO,   {(LEN_W-BYTE_W)'($urandom), c2});
    write_reg(CFG_CODE_THREE, {(LEN_W-BYTE_W)'($urandom), c3});
    write_reg(CFG_CODE_FOUR,  {(LEN_W-BYTE_W)'($urandom), c4});
    write_reg(CFG_MAX_PAYLOAD, limit);
    cfg_valid <= 1'b0;
    plan_code[0] = c1;
    plan_code[1] = c2;
    plan_code[2] = c3;
    plan_code[3] = c4;
    plan_limit   = limit;
    reg_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // reset codes: one-byte length of 2, payload bytes at both extremes
  task automatic test_default_codes();
    send_frame({CODE_ONE_RESET, 8'h02, 8'h00, 8'hFF});
    send_item(OP_CLEAR, 8'hFF);
  endtask

  task automatic test_length_field_sizes();
    // four-byte field holding 1
    send_frame({CODE_FOUR_RESET, 8'h01, 8'h00, 8'h00, 8'h00, 8'h80});
    send_item(OP_CLEAR, 8'h00);
    // 4097 in a two-byte field, one above the reset limit
    send_frame({CODE_TWO_RESET, 8'h01, 8'h10});
    send_item(OP_CLEAR, 8'h55);
    // zero length in a three-byte field
    send_frame({CODE_THREE_RESET, 8'h00, 8'h00, 8'h00});
    send_item(OP_CLEAR, 8'hAA);
  endtask

  // unmatched type byte sticks; the following byte is dropped
  task automatic test_unknown_type();
    send_frame({8'hFF, 8'h01});
    send_item(OP_CLEAR, 8'h7F);
  endtask

  // limit lowered between the two length bytes: length 3 now too long
  task automatic test_register_write_mid_packet();
    send_frame({CODE_TWO_RESET, 8'h03});
    wait_drained();
    program_regs(CODE_ONE_RESET, CODE_TWO_RESET, CODE_THREE_RESET, CODE_FOUR_RESET, 32'd2);
    send_frame({8'h00});
    send_item(OP_CLEAR, 8'h01);
  endtask

  task automatic test_register_extremes();
    wait_drained();
    program_regs(8'hFF, 8'hFF, 8'h80, 8'h00, '1);
    // duplicated code: the one-byte length wins
    send_frame({8'hFF, 8'h01, 8'hC3});
    send_item(OP_CLEAR, 8'h00);
    // largest length under the widest limit, cut short by a clear
    send_frame({8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 8'hA5});
    send_item(OP_CLEAR, 8'h00);
    wait_drained();
    // zero limit refuses every length
    program_regs(8'hFF, 8'h01, 8'h02, 8'h03, '0);
    send_frame({8'hFF, 8'h01});
    send_item(OP_CLEAR, 8'h00);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  task automatic randomise_regs();
    logic [BYTE_W-1:0] c [4];
    logic [LEN_W-1:0]  limit;
    int unsigned       i;
    for (i = 0; i < 4; i++) c[i] = BYTE_W'($urandom);
    case ($urandom_range(0, 5))
      0: c[1] = c[0];
      1: begin
        c[3] = c[2];
        c[2] = c[0];
      end
      2: begin
        c[0] = CODE_ONE_RESET;
        c[1] = CODE_TWO_RESET;
        c[2] = CODE_THREE_RESET;
        c[3] = CODE_FOUR_RESET;
      end
      3: begin
        c[0] = 8'h00;
        c[3] = 8'hFF;
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       limit = '0;
      1:       limit = 32'd1;
      2:       limit = '1;
      3:       limit = $urandom;
      4:       limit = MAX_PAYLOAD_RESET;
      default: limit = $urandom_range(1, 64);
    endcase
    wait_drained();
    program_regs(c[0], c[1], c[2], c[3], limit);
  endtask

  // a clear, then mostly a well-formed packet with random content; the rest
  // is noise, unknown types, bad lengths and frames cut short
  task automatic send_random_packet();
    logic [BYTE_W-1:0] frame [$];
    logic [BYTE_W-1:0] type_byte;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  field_max;
    int unsigned       pick;
    int unsigned       field_bytes;
    int unsigned       cap;
    int unsigned       i;
    send_item(OP_CLEAR, BYTE_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 6))
        send_item(($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_BYTE, BYTE_W'($urandom));
      return;
    end
    if (pick < 11) begin
      do type_byte = BYTE_W'($urandom);
      while (type_byte == plan_code[0] || type_byte == plan_code[1] ||
             type_byte == plan_code[2] || type_byte == plan_code[3]);
      frame = {type_byte, BYTE_W'($urandom)};
    end else begin
      type_byte   = plan_code[$urandom_range(0, 3)];
      field_bytes = 4;
      for (i = 4; i > 0; i--)
        if (plan_code[i-1] == type_byte) field_bytes = i;
      field_max = (field_bytes == 4) ? '1 : LEN_W'((64'd1 << (8 * field_bytes)) - 64'd1);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        length = '0;
      end else if (pick < 14) begin
        // too long: just past the limit where the field can say so
        if (plan_limit < field_max && $urandom_range(0, 1) == 1) begin
          length = plan_limit + 1'b1;
        end else begin
          length = $urandom & field_max;
          if (length <= plan_limit) length = '0;
        end
      end else begin
        cap = ($urandom_range(0, 19) == 0) ? 300 : 24;
        if (cap > field_max)  cap = field_max;
        if (cap > plan_limit) cap = plan_limit;
        length = (cap == 0) ? '0 : LEN_W'($urandom_range(1, cap));
      end
      frame = {type_byte};
      for (i = 0; i < field_bytes; i++) frame.push_back(length[8*i +: BYTE_W]);
      if (length != '0 && length <= plan_limit)
        repeat (length) frame.push_back(BYTE_W'($urandom));
      // trailing bytes land in a sticky phase and are dropped
      repeat ($urandom_range(0, 2)) frame.push_back(BYTE_W'($urandom));
    end
    // now and then the frame stops early; the next clear recovers
    if ($urandom_range(0, 24) == 0) begin
      cap = $urandom_range(1, frame.size());
      while (frame.size() > cap) void'(frame.pop_back());
    end
    send_frame(frame);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    target = useful_items + RANDOM_ITEMS;
    while (useful_items < target) begin
      randomise_regs();
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      if (useful_items + QUIET_TAIL >= target) quiet = 1'b1;
      repeat ($urandom_range(4, 12)) send_random_packet();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_codes();
    test_length_field_sizes();
    test_unknown_type();
    test_register_write_mid_packet();
    test_register_extremes();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      failures += pending_results.size();
      $display("%0d predicted results never arrived", pending_results.size());
    end
    $display("Covered %0d items, %0d results: %0d whole packets, %0d unknown-type, %0d oversize.",
             items_sent, results_seen, packets_done, unknown_ends, oversize_ends);
    $display("Register settings used: %0d; %0d failing results.", reg_phases, failures);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
